/* sv/lruk_pkg.sv */
// ---------------------------------------------------------------------------
// lruk_pkg
// types and constants shared by the lru-k replacement policy block
// ---------------------------------------------------------------------------
package lruk_pkg;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVICT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_VICT = 3'd1,
    ST_FULL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_PINNED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_SCAN_LAST,
    S_COMMIT,
    S_OUT
  } state_e;

  localparam logic [2:0] CFG_K_DEPTH  = 3'd0;
  localparam logic [2:0] CFG_CAPACITY = 3'd1;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the input transaction
    logic lookup;     // read per-frame state of the addressed frame
    logic scan_start; // reset scan index and best candidate
    logic scan_step;  // read one frame, compared the cycle after
    logic commit;     // apply the operation
    logic out_load;   // load the result register
  } lruk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_evict;
    logic scan_last;
  } lruk_sts_t;

endpackage

/* sv/lruk_ctrl.sv */
// ---------------------------------------------------------------------------
// lruk_ctrl
// sequencer for lookup, victim scan, state update and result hand-off
// ---------------------------------------------------------------------------
module lruk_ctrl
  import lruk_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lruk_sts_t sts_i,
  output lruk_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_LOOKUP;
      S_LOOKUP:    state_d = sts_i.is_evict ? S_SCAN : S_COMMIT;
      S_SCAN:      if (sts_i.scan_last) state_d = S_SCAN_LAST;
      S_SCAN_LAST: state_d = S_COMMIT;
      S_COMMIT:    state_d = S_OUT;
      S_OUT:       if (out_ready_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_LOOKUP: begin
        cmd_o.lookup     = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      S_SCAN:      cmd_o.scan_step = 1'b1;
      S_SCAN_LAST: ;
      S_COMMIT: begin
        cmd_o.commit   = 1'b1;
        cmd_o.out_load = 1'b1;
      end
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

/* sv/lruk_dp.sv */
// ---------------------------------------------------------------------------
// lruk_dp
// frame table, time stamp memories, victim scan and result register
// ---------------------------------------------------------------------------
module lruk_dp
  import lruk_pkg::*;
#(
  parameter int N_FRAMES  = 64,
  parameter int MAX_K     = 4,
  parameter int TIME_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lruk_cmd_t  cmd_i,
  output lruk_sts_t  sts_o,
  input  logic [1:0] operation_i,
  input  logic [5:0] frame_id_i,
  input  logic       evictable_flag_i,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [6:0] cfg_wdata_i,
  output logic [5:0] victim_frame_o,
  output logic [2:0] status_o,
  output logic [6:0] evictable_count_o
);

  localparam int FW = $clog2(N_FRAMES);
  localparam int CW = $clog2(N_FRAMES + 1);
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int AW = $clog2(MAX_K + 1);
  localparam int PW = (FW > 6) ? FW : 6;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [MAX_K-1:0][TIME_BITS-1:0] hrow_t;

  logic [2:0] k_cfg_q;
  logic [6:0] cap_cfg_q;

  logic [N_FRAMES-1:0] valid_q, evict_q;
  logic [AW-1:0] acnt_q [N_FRAMES];
  time_t first_mem [N_FRAMES];
  hrow_t hist_mem [N_FRAMES];

  time_t  now_q;
  logic [CW-1:0] tracked_q, evtot_q;

  op_e        op_q;
  logic [PW-1:0] fid_q;
  logic       flag_q;

  logic [FW-1:0] idx_q;
  logic       found_q, best_inf_q;
  time_t      best_age_q;
  logic [FW-1:0] best_q;

  logic [5:0] victim_q;
  status_e    status_q;
  logic [6:0] count_q;

  // effective k and capacity
  logic [AW-1:0] k_eff;
  logic [KW-1:0] k_sel;
  logic [CW:0]   cap_eff;

  always_comb begin
    if (k_cfg_q == 3'd0) k_eff = AW'(1);
    else if (32'(k_cfg_q) > MAX_K) k_eff = AW'(MAX_K);
    else k_eff = AW'(k_cfg_q);
    k_sel = KW'(k_eff - AW'(1));
    if (32'(cap_cfg_q) > N_FRAMES) cap_eff = (CW+1)'(N_FRAMES);
    else cap_eff = (CW+1)'(cap_cfg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q   <= 3'd2;
      cap_cfg_q <= 7'd64;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == CFG_K_DEPTH)  k_cfg_q   <= cfg_wdata_i[2:0];
      if (cfg_addr_i == CFG_CAPACITY) cap_cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(operation_i);
      fid_q  <= PW'(frame_id_i);
      flag_q <= evictable_flag_i;
    end
  end

  logic in_range;
  assign in_range = (32'(fid_q) < N_FRAMES);
  logic [FW-1:0] fi;
  assign fi = FW'(fid_q);

  // looked-up frame state
  logic          known_q, ev_f_q;
  logic [AW-1:0] acnt_f_q;
  hrow_t         hist_f_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      known_q  <= in_range && valid_q[fi];
      ev_f_q   <= evict_q[fi];
      acnt_f_q <= acnt_q[fi];
      hist_f_q <= hist_mem[fi];
    end
  end

  // scan: one frame read per cycle, compared the cycle after
  logic          cmp_en_q;
  logic [FW-1:0] cmp_idx_q;
  time_t         first_rd_q;
  hrow_t         hist_rd_q;
  logic          c_inf;
  time_t         c_age;
  logic          c_take;

  assign sts_o.is_evict  = (op_q == OP_EVICT);
  assign sts_o.scan_last = (32'(idx_q) == N_FRAMES - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      first_rd_q <= first_mem[idx_q];
      hist_rd_q  <= hist_mem[idx_q];
      cmp_idx_q  <= idx_q;
    end
  end

  always_comb begin
    c_inf  = acnt_q[cmp_idx_q] < k_eff;
    c_age  = c_inf ? (now_q - first_rd_q) : (now_q - hist_rd_q[k_sel]);
    c_take = cmp_en_q && valid_q[cmp_idx_q] && evict_q[cmp_idx_q] &&
             (!found_q || (c_inf && !best_inf_q) ||
              (c_inf == best_inf_q && c_age > best_age_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      found_q  <= 1'b0;
      cmp_en_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_step) idx_q <= idx_q + FW'(1);
        if (c_take) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_take) begin
      best_inf_q <= c_inf;
      best_age_q <= c_age;
      best_q     <= cmp_idx_q;
    end
  end

  // commit decision
  logic          do_stamp, do_new, do_drop, do_set;
  logic [FW-1:0] tgt;
  status_e       st;

  always_comb begin
    do_stamp = 1'b0;
    do_new   = 1'b0;
    do_drop  = 1'b0;
    do_set   = 1'b0;
    tgt      = fi;
    st       = ST_OK;
    unique case (op_q)
      OP_ACCESS: begin
        if (!in_range) st = ST_UNKNOWN;
        else if (known_q) do_stamp = 1'b1;
        else if ((CW+1)'(tracked_q) >= cap_eff) st = ST_FULL;
        else begin
          do_new   = 1'b1;
          do_stamp = 1'b1;
        end
      end
      OP_SET: begin
        if (!known_q) st = ST_UNKNOWN;
        else do_set = (ev_f_q != flag_q);
      end
      OP_REMOVE: begin
        if (!in_range) st = ST_UNKNOWN;
        else if (known_q) begin
          if (!ev_f_q) st = ST_PINNED;
          else do_drop = 1'b1;
        end
      end
      OP_EVICT: begin
        tgt = best_q;
        if (!found_q) st = ST_NO_VICT;
        else do_drop = 1'b1;
      end
      default: ;
    endcase
  end

  logic [CW-1:0] evtot_d, tracked_d;
  always_comb begin
    evtot_d   = evtot_q;
    tracked_d = tracked_q;
    if (do_new) begin
      evtot_d   = evtot_q + CW'(1);
      tracked_d = tracked_q + CW'(1);
    end
    if (do_set) begin
      if (flag_q) evtot_d = evtot_q + CW'(1);
      else if (evtot_q != '0) evtot_d = evtot_q - CW'(1);
    end
    if (do_drop) begin
      if (evtot_q != '0) evtot_d = evtot_q - CW'(1);
      if (tracked_q != '0) tracked_d = tracked_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      evict_q   <= '0;
      for (int i = 0; i < N_FRAMES; i++) acnt_q[i] <= '0;
      now_q     <= '0;
      tracked_q <= '0;
      evtot_q   <= '0;
    end else if (cmd_i.commit) begin
      tracked_q <= tracked_d;
      evtot_q   <= evtot_d;
      if (do_stamp) begin
        now_q <= now_q + time_t'(1);
        if (do_new) acnt_q[tgt] <= AW'(1);
        else if (32'(acnt_f_q) < MAX_K) acnt_q[tgt] <= acnt_f_q + AW'(1);
      end
      if (do_new) begin
        valid_q[tgt] <= 1'b1;
        evict_q[tgt] <= 1'b1;
      end
      if (do_set) evict_q[tgt] <= flag_q;
      if (do_drop) begin
        valid_q[tgt] <= 1'b0;
        evict_q[tgt] <= 1'b0;
        acnt_q[tgt]  <= '0;
      end
    end
  end

  // history row of the stamped frame, newest first
  hrow_t hist_new;
  always_comb begin
    hist_new[0] = now_q;
    for (int j = 1; j < MAX_K; j++) hist_new[j] = hist_f_q[j-1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_stamp) begin
      if (do_new) first_mem[tgt] <= now_q;
      hist_mem[tgt] <= hist_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      victim_q <= (op_q == OP_EVICT && found_q) ? 6'(best_q) : 6'd0;
      status_q <= st;
      count_q  <= (32'(evtot_d) > 127) ? 7'd127 : 7'(evtot_d);
    end
  end

  assign victim_frame_o    = victim_q;
  assign status_o          = status_q;
  assign evictable_count_o = count_q;

endmodule

/* sv/lru_k_replacement_policy.sv */
// order: capture, lookup, commit with result load, then the result is held valid until taken;
// evict scans every frame and drains the last comparison between lookup and commit
// throughput: one transaction at a time, a new one accepted only after the result is taken;
// the evict scan reads one frame per cycle
// reset: all frames untracked, time and counters zero, k_depth 2, capacity 64
// ---------------------------------------------------------------------------
// lru_k_replacement_policy
// lru-k victim selector, controller plus datapath
// ---------------------------------------------------------------------------
module lru_k_replacement_policy
  import lruk_pkg::*;
#(
  parameter int N_FRAMES  = 64,
  parameter int MAX_K     = 4,
  parameter int TIME_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [5:0] frame_id_i,
  input  logic       evictable_flag_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] victim_frame_o,
  output logic [2:0] status_o,
  output logic [6:0] evictable_count_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [6:0] cfg_wdata_i
);

  lruk_cmd_t cmd;
  lruk_sts_t sts;

  lruk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lruk_dp #(
    .N_FRAMES  (N_FRAMES),
    .MAX_K     (MAX_K),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (operation_i),
    .frame_id_i        (frame_id_i),
    .evictable_flag_i  (evictable_flag_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .victim_frame_o    (victim_frame_o),
    .status_o          (status_o),
    .evictable_count_o (evictable_count_o)
  );

endmodule
